// ===== hdl/mp2d_pkg.sv =====
// shared types and register index codes for the 2-d max pooling stream block
package mp2d_pkg;

  typedef logic [1:0] cfg_idx_t;
  typedef logic [7:0] cfg_data_t;
  typedef logic [7:0] pixel_t;

  localparam cfg_idx_t REG_IN_COLS      = 2'd0;
  localparam cfg_idx_t REG_IN_ROWS      = 2'd1;
  localparam cfg_idx_t REG_NUM_CHANNELS = 2'd2;

  localparam int COLS_RESET     = 128;
  localparam int ROWS_RESET     = 128;
  localparam int CHANNELS_RESET = 64;

endpackage

// ===== hdl/max_pool_2d_uint8_stream_top.sv =====
// streaming 2-d max pooling of an unsigned 8-bit feature map, window equal to stride
// a result passes through the compare stage and then the result register before out_valid
// throughput: one input transaction per cycle unless out_ready stalls a pending result;
//   partial maximum memory read-modify-write is forwarded between back-to-back transactions
// reset: synchronous active-low rst_n clears position counters and valid flags, loads
//   map size 128 x 128 with 64 channels; the partial maximum memory is not cleared
module max_pool_2d_uint8_stream_top #(
  parameter int WINDOW       = 2,
  parameter int MAX_COLS     = 128,
  parameter int MAX_ROWS     = 128,
  parameter int MAX_CHANNELS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mp2d_pkg::pixel_t     in_pixel_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mp2d_pkg::pixel_t     out_pooled_value,
  output logic                 out_map_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  mp2d_pkg::cfg_idx_t   cfg_index,
  input  mp2d_pkg::cfg_data_t  cfg_data
);
  import mp2d_pkg::*;

  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int HW    = $clog2(MAX_CHANNELS + 1);
  localparam int WW    = $clog2(WINDOW);
  localparam int CEW   = $clog2(MAX_COLS + 2 * WINDOW + 1);
  localparam int REW   = $clog2(MAX_ROWS + 2 * WINDOW + 1);
  localparam int DEPTH = (MAX_COLS / WINDOW) * MAX_CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COLS_RST  = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;
  localparam int ROWS_RST  = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;
  localparam int CHANS_RST = (CHANNELS_RESET > MAX_CHANNELS) ? MAX_CHANNELS : CHANNELS_RESET;

  // configuration
  logic [CW-1:0] cols_r;
  logic [RW-1:0] rows_r;
  logic [HW-1:0] chans_r;
  logic [CW-1:0] cols_clamp;
  logic [RW-1:0] rows_clamp;
  logic [HW-1:0] chans_clamp;
  logic          cfg_fire;
  logic          cfg_hit;

  // position counters
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [HW-1:0] ch_r, ch_nxt;
  logic [WW-1:0] wc_r, wc_nxt;
  logic [WW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] base_r, base_nxt;

  // window decode
  logic [CEW-1:0] col_end;
  logic [REW-1:0] row_end;
  logic           col_ok, row_ok, col_last, row_last;
  logic           item_first, item_emit, item_last;
  logic [AW-1:0]  rd_idx;
  logic           in_fire;

  // compare stage
  logic          s1_valid_r;
  pixel_t        s1_value_r;
  logic [AW-1:0] s1_idx_r;
  logic          s1_first_r, s1_wr_r, s1_emit_r, s1_last_r;
  pixel_t        mem_rd_r;
  logic          fwd_r;
  pixel_t        fwd_data_r;
  pixel_t        held_max;
  pixel_t        new_max;
  logic          s1_move;
  logic          mem_we;

  // result register
  logic          out_valid_r, out_valid_nxt;
  pixel_t        out_pooled_value_r;
  logic          out_map_done_r;

  pixel_t        partial_max [DEPTH];

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign cfg_hit   = cfg_fire & ((cfg_index == REG_IN_COLS) || (cfg_index == REG_IN_ROWS) ||
                                 (cfg_index == REG_NUM_CHANNELS));

  always_comb begin
    if (cfg_data == '0) begin
      cols_clamp = CW'(1);
    end else if (32'(cfg_data) > 32'(MAX_COLS)) begin
      cols_clamp = CW'(MAX_COLS);
    end else begin
      cols_clamp = CW'(cfg_data);
    end
    if (cfg_data == '0) begin
      rows_clamp = RW'(1);
    end else if (32'(cfg_data) > 32'(MAX_ROWS)) begin
      rows_clamp = RW'(MAX_ROWS);
    end else begin
      rows_clamp = RW'(cfg_data);
    end
    if (cfg_data[6:0] == '0) begin
      chans_clamp = HW'(1);
    end else if (32'(cfg_data[6:0]) > 32'(MAX_CHANNELS)) begin
      chans_clamp = HW'(MAX_CHANNELS);
    end else begin
      chans_clamp = HW'(cfg_data[6:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= CW'(COLS_RST);
      rows_r  <= RW'(ROWS_RST);
      chans_r <= HW'(CHANS_RST);
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_IN_COLS:      cols_r  <= cols_clamp;
        REG_IN_ROWS:      rows_r  <= rows_clamp;
        REG_NUM_CHANNELS: chans_r <= chans_clamp;
        default:          ;
      endcase
    end
  end

  // window decode from the current position
  always_comb begin
    col_end    = CEW'(col_r) + CEW'(WINDOW) - CEW'(wc_r);
    row_end    = REW'(row_r) + REW'(WINDOW) - REW'(wr_r);
    col_ok     = col_end <= CEW'(cols_r);
    row_ok     = row_end <= REW'(rows_r);
    col_last   = (col_end + CEW'(WINDOW)) > CEW'(cols_r);
    row_last   = (row_end + REW'(WINDOW)) > REW'(rows_r);
    item_first = (wc_r == '0) && (wr_r == '0);
    item_emit  = (wc_r == WW'(WINDOW - 1)) && (wr_r == WW'(WINDOW - 1));
    item_last  = item_emit && row_last && col_last && (ch_r == chans_r - HW'(1));
    rd_idx     = AW'(base_r + AW'(ch_r));
  end

  always_comb begin
    ch_nxt   = ch_r + HW'(1);
    col_nxt  = col_r;
    row_nxt  = row_r;
    wc_nxt   = wc_r;
    wr_nxt   = wr_r;
    base_nxt = base_r;
    if (ch_r == chans_r - HW'(1)) begin
      ch_nxt = '0;
      if (col_r == cols_r - CW'(1)) begin
        col_nxt  = '0;
        wc_nxt   = '0;
        base_nxt = '0;
        if (row_r == rows_r - RW'(1)) begin
          row_nxt = '0;
          wr_nxt  = '0;
        end else begin
          row_nxt = row_r + RW'(1);
          wr_nxt  = (wr_r == WW'(WINDOW - 1)) ? '0 : wr_r + WW'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
        if (wc_r == WW'(WINDOW - 1)) begin
          wc_nxt   = '0;
          base_nxt = AW'(base_r + AW'(MAX_CHANNELS));
        end else begin
          wc_nxt = wc_r + WW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      col_r  <= '0;
      row_r  <= '0;
      ch_r   <= '0;
      wc_r   <= '0;
      wr_r   <= '0;
      base_r <= '0;
    end else if (in_fire) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ch_r   <= ch_nxt;
      wc_r   <= wc_nxt;
      wr_r   <= wr_nxt;
      base_r <= base_nxt;
    end
  end

  // handshake and stage advance
  assign s1_move  = s1_valid_r & (~s1_emit_r | ~s1_wr_r | ~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_move;
  assign in_fire  = in_valid & in_ready;
  assign mem_we   = s1_move & s1_wr_r;

  always_comb begin
    held_max = fwd_r ? fwd_data_r : mem_rd_r;
    if (s1_first_r || (s1_value_r > held_max)) begin
      new_max = s1_value_r;
    end else begin
      new_max = held_max;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_value_r <= in_pixel_value;
      s1_idx_r   <= rd_idx;
      s1_first_r <= item_first;
      s1_wr_r    <= row_ok & col_ok;
      s1_emit_r  <= item_emit;
      s1_last_r  <= item_last;
      fwd_r      <= mem_we && (s1_idx_r == rd_idx);
      fwd_data_r <= new_max;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_rd_r <= partial_max[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      partial_max[s1_idx_r] <= new_max;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ready;
    if (s1_move && s1_wr_r && s1_emit_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_wr_r && s1_emit_r) begin
      out_pooled_value_r <= new_max;
      out_map_done_r     <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pooled_value = out_pooled_value_r;
  assign out_map_done     = out_map_done_r;

`ifndef SYNTH
  ap_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ch_r < chans_r) && (col_r < cols_r) && (row_r < rows_r))
    else $error("position counter outside map");

  ap_last_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r && s1_wr_r |-> s1_emit_r)
    else $error("map end flagged off a window corner");

  ap_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(s1_move && s1_wr_r && s1_emit_r))
    else $error("result register overwritten while stalled");

  ap_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted transaction lost before compare stage");
`endif

endmodule

// ===== tb/max_pool_2d_uint8_stream_top_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the 2-d max pooling stream block, with its own pooling predictor
module max_pool_2d_uint8_stream_top_tb;
  import mp2d_pkg::*;

  localparam int WINDOW        = 2;
  localparam int MAX_COLS      = 128;
  localparam int MAX_ROWS      = 128;
  localparam int MAX_CHANNELS  = 64;
  localparam int POOL_DEPTH    = (MAX_COLS / WINDOW) * MAX_CHANNELS;
  localparam int ITEM_TOTAL    = 1650;
  localparam int RANDOM_TARGET = 850;
  localparam int IDLE_GAP      = 6;
  localparam int LONG_STALL    = 400;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 200000;
  localparam cfg_idx_t REG_SPARE = 2'd3;

  typedef struct packed {
    pixel_t value;
    logic   done;
  } pooled_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  pixel_t    in_pixel_value = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  pixel_t    out_pooled_value;
  logic      out_map_done;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = REG_IN_COLS;
  cfg_data_t cfg_data = '0;

  pixel_t  pixel_q[$];
  pooled_t pooled_q[$];

  // predictor state
  logic [7:0] map_cols_reg = 8'(COLS_RESET);
  logic [7:0] map_rows_reg = 8'(ROWS_RESET);
  logic [6:0] map_chans_reg = 7'(CHANNELS_RESET);
  int row_pos = 0;
  int col_pos = 0;
  int chan_pos = 0;
  pixel_t window_max [POOL_DEPTH];

  int send_idle_pct = 27;
  int recv_idle_pct = 78;
  int stall_requests = 0;
  int stall_served = 0;
  int stall_left = 0;
  int fail_count = 0;
  int pixels_sent = 0;
  int pooled_seen = 0;
  int queued_total = 0;
  int settings_used = 0;
  int cycle_count = 0;

  max_pool_2d_uint8_stream_top #(
    .WINDOW(WINDOW),
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pixel_value(in_pixel_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pooled_value(out_pooled_value),
    .out_map_done(out_map_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_dim(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // advance the window position by one pixel and queue the pooled value it completes
  function automatic void pool_pixel(input pixel_t v);
    int cols, rows, chans, pooled_cols, pooled_rows, slot;
    pixel_t m;
    pooled_t res;
    cols = clamp_dim(map_cols_reg, MAX_COLS);
    rows = clamp_dim(map_rows_reg, MAX_ROWS);
    chans = clamp_dim(map_chans_reg, MAX_CHANNELS);
    pooled_cols = cols / WINDOW;
    pooled_rows = rows / WINDOW;
    if (row_pos < pooled_rows * WINDOW && col_pos < pooled_cols * WINDOW && chan_pos < chans) begin
      slot = (col_pos / WINDOW) * MAX_CHANNELS + chan_pos;
      if (row_pos % WINDOW == 0 && col_pos % WINDOW == 0) begin
        m = v;
      end else begin
        m = (v > window_max[slot]) ? v : window_max[slot];
      end
      window_max[slot] = m;
      if (row_pos % WINDOW == WINDOW - 1 && col_pos % WINDOW == WINDOW - 1) begin
        res.value = m;
        res.done = (row_pos / WINDOW == pooled_rows - 1) &&
                   (col_pos / WINDOW == pooled_cols - 1) && (chan_pos == chans - 1);
        pooled_q.push_back(res);
      end
    end
    chan_pos++;
    if (chan_pos >= chans) begin
      chan_pos = 0;
      col_pos++;
      if (col_pos >= cols) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= rows) row_pos = 0;
      end
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pool_pixel(in_pixel_value);
        pixels_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_pixel_value <= pixel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    pooled_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        pooled_seen++;
        if (pooled_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected pooled result: value %0d done %0b",
                     out_pooled_value, out_map_done);
        end else begin
          want = pooled_q.pop_front();
          if (out_pooled_value !== want.value || out_map_done !== want.done) begin
            fail_count++;
            if (fail_count <= 10)
              $display("pooled result mismatch: expected value %0d done %0b, got value %0d done %0b",
                       want.value, want.done, out_pooled_value, out_map_done);
          end
        end
      end
      out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_served != stall_requests) begin
      stall_left <= LONG_STALL;
      stall_served <= stall_served + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("max_pool_2d_uint8_stream_top regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    logic hit;
    hit = 1'b1;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_IN_COLS: map_cols_reg = val;
      REG_IN_ROWS: map_rows_reg = val;
      REG_NUM_CHANNELS: map_chans_reg = val[6:0];
      default: hit = 1'b0;
    endcase
    if (hit) begin
      row_pos = 0;
      col_pos = 0;
      chan_pos = 0;
    end
  endtask

  // all transactions accepted and all pooled values back, then let the pipeline empty
  task automatic settle();
    do @(negedge clk); while (pixel_q.size() != 0 || in_valid || pooled_q.size() != 0);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic begin_phase();
    @(negedge clk);
    settings_used++;
    if (queued_total < ITEM_TOTAL / 3) begin
      send_idle_pct = 27;
      recv_idle_pct = 78;
    end else if (queued_total < 2 * ITEM_TOTAL / 3) begin
      send_idle_pct = 78;
      recv_idle_pct = 27;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic queue_pixel(input pixel_t v);
    pixel_q.push_back(v);
    queued_total++;
  endtask

  task automatic queue_window(input pixel_t a, input pixel_t b, input pixel_t c, input pixel_t d);
    queue_pixel(a);
    queue_pixel(b);
    queue_pixel(c);
    queue_pixel(d);
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_pixel(pixel_t'($urandom_range(255)));
  endtask

  initial begin : stimulus
    int cols_raw, rows_raw, chans_raw, map_len, n, random_used;
    random_used = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset map size: first row never closes a window
    begin_phase();
    queue_window(8'hFF, 8'h00, 8'h80, 8'h7F);
    settle();

    write_reg(REG_IN_COLS, 8'd2);
    write_reg(REG_IN_ROWS, 8'd2);
    write_reg(REG_NUM_CHANNELS, 8'd1);
    begin_phase();
    queue_window(8'd0, 8'd0, 8'd0, 8'd0);
    queue_window(8'd255, 8'd1, 8'd2, 8'd3);
    queue_window(8'd7, 8'd9, 8'd8, 8'd254);
    settle();

    // odd width, trailing column dropped
    write_reg(REG_IN_COLS, 8'd3);
    begin_phase();
    queue_window(8'd10, 8'd20, 8'd255, 8'd30);
    queue_pixel(8'd5);
    queue_pixel(8'd255);
    settle();

    // zero width acts as one, map smaller than a window
    write_reg(REG_IN_COLS, 8'd0);
    begin_phase();
    queue_pixel(8'd255);
    queue_pixel(8'd255);
    settle();

    // spare index leaves the position alone
    write_reg(REG_IN_COLS, 8'd2);
    begin_phase();
    queue_pixel(8'd3);
    queue_pixel(8'd4);
    settle();
    write_reg(REG_SPARE, 8'hA5);
    begin_phase();
    queue_pixel(8'd6);
    queue_pixel(8'd5);
    settle();

    // widest map, sender pauses mid map until drained
    write_reg(REG_IN_COLS, 8'd128);
    begin_phase();
    queue_random(192);
    settle();
    queue_random(64);
    settle();

    // saturated height under a long receiver hold-off
    write_reg(REG_IN_ROWS, 8'd255);
    write_reg(REG_IN_COLS, 8'd2);
    begin_phase();
    stall_requests++;
    queue_random(256);
    settle();

    // saturated channel count
    write_reg(REG_IN_ROWS, 8'd2);
    write_reg(REG_NUM_CHANNELS, 8'd127);
    begin_phase();
    queue_random(256);
    settle();

    while (random_used < RANDOM_TARGET) begin
      cols_raw = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 8);
      rows_raw = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 8);
      chans_raw = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 4);
      write_reg(REG_IN_COLS, cfg_data_t'(cols_raw));
      write_reg(REG_IN_ROWS, cfg_data_t'(rows_raw));
      write_reg(REG_NUM_CHANNELS, cfg_data_t'(chans_raw));
      if ($urandom_range(3) == 0) write_reg(REG_SPARE, cfg_data_t'($urandom_range(255)));
      map_len = clamp_dim(cols_raw, MAX_COLS) * clamp_dim(rows_raw, MAX_ROWS) *
                clamp_dim(chans_raw, MAX_CHANNELS);
      if (map_len > 160) n = $urandom_range(1, 64);
      else if ($urandom_range(4) == 0) n = $urandom_range(1, map_len);
      else n = map_len * $urandom_range(1, 2);
      if (clamp_dim(cols_raw, MAX_COLS) >= WINDOW && clamp_dim(rows_raw, MAX_ROWS) >= WINDOW)
        random_used += n;
      begin_phase();
      queue_random(n);
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pooled_q.size() != 0) begin
      fail_count += pooled_q.size();
      $display("%0d pooled results never arrived", pooled_q.size());
    end
    $display("checked %0d pooled results from %0d pixel transactions over %0d map settings",
             pooled_seen, pixels_sent, settings_used);
    $display("saturated and zero sizes, odd edges, spare index, long back-pressure, drained restart");
    if (fail_count == 0) begin
      $display("max_pool_2d_uint8_stream_top regression: pass");
    end else begin
      $display("max_pool_2d_uint8_stream_top regression: fail");
    end
    $finish;
  end

endmodule
